// ----- hw/rtl/deb_pkg.sv -----
// ----------------------------------------------------------------------------
// deb_pkg
// Types and constants shared by the double-ended word buffer and its testbench.
// ----------------------------------------------------------------------------
`default_nettype none

package deb_pkg;

  // default number of stored words
  localparam int DEB_CAPACITY = 16;

  // command codes
  typedef enum logic [2:0] {
    FUNC_DUMP       = 3'd0,
    FUNC_PUSH_BACK  = 3'd1,
    FUNC_PUSH_FRONT = 3'd2,
    FUNC_POP_BACK   = 3'd3,
    FUNC_POP_FRONT  = 3'd4,
    FUNC_REVERSE    = 3'd5
  } func_t;

  // status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // command payload
  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] value;
  } cmd_t;

  // response payload
  typedef struct packed {
    logic signed [31:0] data;
    logic               item_valid;
    logic [4:0]         fill_level;
    logic [1:0]         status;
    logic               last;
  } rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/deb_ram.sv -----
// ----------------------------------------------------------------------------
// deb_ram
// Generic simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module deb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/double_ended_buffer_with_reverse.sv -----
// Non-dump command: the transfer moves the sequencer to S_EXEC, which loads the
//   response register and returns to S_IDLE, where the next command is taken.
// Dump of n words: after command decode in S_EXEC, each word takes a RAM read
//   (S_READ), then a response load (S_LOAD), through the single read port.
// A response held by rsp_ready low stalls the sequencer until it is taken.
// Reset (synchronous, active high) empties the buffer; no clearing pass.
// ----------------------------------------------------------------------------
// double_ended_buffer_with_reverse
// Double-ended word buffer held as a circular RAM with a head pointer and a
// direction flag, so reverse and front operations move no stored data.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_buffer_with_reverse #(
  parameter int CAPACITY = deb_pkg::DEB_CAPACITY
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire deb_pkg::cmd_t cmd,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output deb_pkg::rsp_t      rsp
);

  import deb_pkg::*;

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW:0]   CAP_W = (CW + 1)'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_LOAD = 4'b1000
  } state_t;

  state_t             state, state_next;
  logic [PW-1:0]      head, head_next;
  logic               dir, dir_next;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      idx, idx_next;
  logic [2:0]         func_q;
  logic signed [31:0] value_q;
  rsp_t               rsp_next;
  logic               load_rsp;
  logic               free;

  // address unit signals
  logic [CW-1:0] u_off;
  logic          u_down;
  logic [CW:0]   u_sum;
  logic [PW-1:0] u_addr;

  // ram signals
  logic          we;
  logic          re;
  logic [31:0]   rdata;

  assign cmd_ready = (state == S_IDLE);
  assign free      = !rsp_valid || rsp_ready;

  // offset select for the shared address unit
  always_comb begin
    u_off  = idx;
    u_down = dir;
    if (state == S_EXEC) begin
      case (func_q)
        FUNC_PUSH_BACK: begin
          u_off = count;
        end
        FUNC_PUSH_FRONT: begin
          u_off  = ONE_C;
          u_down = !dir;
        end
        FUNC_POP_FRONT: begin
          u_off = ONE_C;
        end
        FUNC_REVERSE: begin
          u_off = count - ONE_C;
        end
        default: begin
          u_off = idx;
        end
      endcase
    end
  end

  // shared address unit: head stepped by an offset, modulo capacity
  always_comb begin
    logic [CW:0] b;
    logic [CW:0] o;
    b = (CW + 1)'(head);
    o = {1'b0, u_off};
    if (u_down) begin
      if (b >= o) begin
        u_sum = b - o;
      end else begin
        u_sum = b + CAP_W - o;
      end
    end else begin
      u_sum = b + o;
      if (u_sum >= CAP_W) begin
        u_sum = u_sum - CAP_W;
      end
    end
    u_addr = u_sum[PW-1:0];
  end

  // sequencer
  always_comb begin
    state_next = state;
    head_next  = head;
    dir_next   = dir;
    count_next = count;
    idx_next   = idx;
    we         = 1'b0;
    re         = 1'b0;
    load_rsp   = 1'b0;
    rsp_next   = '0;
    rsp_next.last = 1'b1;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (func_q == FUNC_DUMP && count != '0) begin
          idx_next   = '0;
          state_next = S_READ;
        end else if (free) begin
          load_rsp   = 1'b1;
          state_next = S_IDLE;
          rsp_next.status = STAT_OK;
          case (func_q)
            FUNC_PUSH_BACK: begin
              if (count == CAP_W[CW-1:0]) begin
                rsp_next.status = STAT_FULL;
              end else begin
                we         = 1'b1;
                count_next = count + ONE_C;
              end
            end
            FUNC_PUSH_FRONT: begin
              if (count == CAP_W[CW-1:0]) begin
                rsp_next.status = STAT_FULL;
              end else begin
                we         = 1'b1;
                head_next  = u_addr;
                count_next = count + ONE_C;
              end
            end
            FUNC_POP_BACK: begin
              if (count == '0) begin
                rsp_next.status = STAT_EMPTY;
              end else begin
                count_next = count - ONE_C;
              end
            end
            FUNC_POP_FRONT: begin
              if (count == '0) begin
                rsp_next.status = STAT_EMPTY;
              end else begin
                head_next  = u_addr;
                count_next = count - ONE_C;
              end
            end
            FUNC_REVERSE: begin
              dir_next = !dir;
              if (count != '0) begin
                head_next = u_addr;
              end
            end
            default: begin
              rsp_next.status = STAT_OK;
            end
          endcase
          rsp_next.fill_level = 5'(count_next);
        end
      end
      S_READ: begin
        re         = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (free) begin
          load_rsp            = 1'b1;
          rsp_next.data       = rdata;
          rsp_next.item_valid = 1'b1;
          rsp_next.fill_level = 5'(count);
          rsp_next.status     = STAT_OK;
          rsp_next.last       = ((CW + 1)'(idx) + (CW + 1)'(1)) == {1'b0, count};
          if (rsp_next.last) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = idx + ONE_C;
            state_next = S_READ;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      dir       <= 1'b0;
      count     <= '0;
      idx       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      dir   <= dir_next;
      count <= count_next;
      idx   <= idx_next;
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // command capture and response register
  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      func_q  <= cmd.func;
      value_q <= cmd.value;
    end
    if (load_rsp) begin
      rsp <= rsp_next;
    end
  end

  // word storage
  deb_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (u_addr),
    .wdata (value_q),
    .re    (re),
    .raddr (u_addr),
    .rdata (rdata)
  );

endmodule

`default_nettype wire

// ----- dv/double_ended_buffer_with_reverse_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_buffer_with_reverse_test
// Drives push, pop, reverse and dump commands into the double-ended word
// buffer and checks every response against a queue-based copy of the buffer.
// Both sides stall in random bursts; the last part of the run has no stalls.
// ----------------------------------------------------------------------------

module double_ended_buffer_with_reverse_test;

  import deb_pkg::*;

  localparam int          CLK_HALF    = 6;
  localparam int          RST_CYCLES  = 8;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          RANDOM_CMDS = 280;
  localparam int          QUIET_CMDS  = 40;
  localparam int          DRAIN_WAIT  = 40;
  localparam logic [2:0]  FUNC_SPARE6 = 3'd6;
  localparam logic [2:0]  FUNC_SPARE7 = 3'd7;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

  // copy of the buffer contents and the responses still owed
  class word_deque_check;
    logic signed [31:0] words[$];
    rsp_t               pending_rsps[$];
    int                 errors = 0;

    function void owe_rsp(logic signed [31:0] d, logic v, status_t st, logic lst);
      rsp_t r;
      r.data       = d;
      r.item_valid = v;
      r.fill_level = 5'(words.size());
      r.status     = st;
      r.last       = lst;
      pending_rsps.push_back(r);
    endfunction

    // work out the responses for one accepted command
    function void predict_cmd(cmd_t c);
      status_t            st;
      logic signed [31:0] tmp;
      int                 n;
      st = STAT_OK;
      n  = words.size();
      case (c.func)
        FUNC_DUMP: begin
          if (n == 0) begin
            owe_rsp('0, 1'b0, STAT_OK, 1'b1);
          end else begin
            for (int i = 0; i < n; i++) owe_rsp(words[i], 1'b1, STAT_OK, i == n - 1);
          end
          return;
        end
        FUNC_PUSH_BACK: begin
          if (n >= DEB_CAPACITY) st = STAT_FULL;
          else words.push_back(c.value);
        end
        FUNC_PUSH_FRONT: begin
          if (n >= DEB_CAPACITY) st = STAT_FULL;
          else words.push_front(c.value);
        end
        FUNC_POP_BACK: begin
          if (n == 0) st = STAT_EMPTY;
          else void'(words.pop_back());
        end
        FUNC_POP_FRONT: begin
          if (n == 0) st = STAT_EMPTY;
          else void'(words.pop_front());
        end
        FUNC_REVERSE: begin
          for (int i = 0; i < n / 2; i++) begin
            tmp              = words[i];
            words[i]         = words[n - 1 - i];
            words[n - 1 - i] = tmp;
          end
        end
        default: ;
      endcase
      owe_rsp('0, 1'b0, st, 1'b1);
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // compare one response with the oldest one owed
    function void compare_rsp(rsp_t got);
      rsp_t want;
      if (pending_rsps.size() == 0) begin
        $display("%0t ns: unexpected response, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = pending_rsps.pop_front();
      field_check("data", want.data, got.data);
      field_check("item_valid", 32'(want.item_valid), 32'(got.item_valid));
      field_check("fill_level", 32'(want.fill_level), 32'(got.fill_level));
      field_check("status", 32'(want.status), 32'(got.status));
      field_check("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic  clk       = 1'b0;
  logic  rst       = 1'b1;
  logic  cmd_valid = 1'b0;
  logic  cmd_ready;
  cmd_t  cmd       = '0;
  logic  rsp_valid;
  logic  rsp_ready = 1'b1;
  rsp_t  rsp;

  int unsigned     idle_odds   = 2;
  logic            quiet       = 1'b0;
  int unsigned     cycle_count = 0;
  word_deque_check sb          = new;

  double_ended_buffer_with_reverse dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // check each response transfer
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.compare_rsp(rsp);
  end

  // response side stalls in bursts
  initial begin : rsp_stalls
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!quiet && idle_odds != 0 && $urandom_range(15, 0) < idle_odds) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(10, 1)) @(posedge clk);
        rsp_ready <= 1'b1;
      end
    end
  end

  // one command transfer, then maybe a gap
  task automatic send_cmd(input logic [2:0] f, input logic signed [31:0] v);
    cmd_t c;
    c.func  = f;
    c.value = v;
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (!cmd_ready);
    sb.predict_cmd(c);
    if (!quiet && idle_odds != 0 && $urandom_range(15, 0) < idle_odds) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(10, 1)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_value();
    if ($urandom_range(7, 0) != 0) return $urandom;
    case ($urandom_range(3, 0))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // command mix leans toward filling or draining in those phases; the mixed phase picks any code
  function automatic logic [2:0] pick_func(phase_t ph);
    int unsigned r;
    r = $urandom_range(19, 0);
    if (ph == PH_MIXED) return 3'($urandom_range(FUNC_SPARE7, FUNC_DUMP));
    if (r < 2) return FUNC_DUMP;
    if (r < 4) return FUNC_REVERSE;
    if (r == 4) return (r[0] ? FUNC_SPARE6 : FUNC_SPARE7);
    if (ph == PH_FILL) begin
      if (r < 12) return FUNC_PUSH_BACK;
      if (r < 18) return FUNC_PUSH_FRONT;
      return (r[0] ? FUNC_POP_BACK : FUNC_POP_FRONT);
    end
    if (r < 12) return FUNC_POP_BACK;
    if (r < 18) return FUNC_POP_FRONT;
    return (r[0] ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT);
  endfunction

  initial begin : stimulus
    int unsigned phase_left;
    phase_t      ph;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // empty buffer, spare codes, extreme words, reverse and both pops
    send_cmd(FUNC_DUMP, 32'sd0);
    send_cmd(FUNC_POP_BACK, 32'sd0);
    send_cmd(FUNC_POP_FRONT, -32'sd1);
    send_cmd(FUNC_REVERSE, 32'sd0);
    send_cmd(FUNC_SPARE6, 32'h7fff_ffff);
    send_cmd(FUNC_SPARE7, 32'h8000_0000);
    send_cmd(FUNC_PUSH_BACK, 32'h8000_0000);
    send_cmd(FUNC_PUSH_FRONT, 32'h7fff_ffff);
    send_cmd(FUNC_PUSH_BACK, 32'sd0);
    send_cmd(FUNC_PUSH_FRONT, -32'sd1);
    send_cmd(FUNC_DUMP, 32'sd0);
    send_cmd(FUNC_REVERSE, 32'sd0);
    send_cmd(FUNC_DUMP, 32'sd0);
    send_cmd(FUNC_POP_BACK, 32'sd0);
    send_cmd(FUNC_POP_FRONT, 32'sd0);
    send_cmd(FUNC_DUMP, 32'sd0);
    send_cmd(FUNC_POP_BACK, 32'sd0);
    send_cmd(FUNC_REVERSE, 32'sd0);
    send_cmd(FUNC_DUMP, 32'sd0);
    send_cmd(FUNC_POP_FRONT, 32'sd0);

    // random phases; the first one leans toward filling the buffer
    ph         = PH_FILL;
    phase_left = 30;
    for (int i = 0; i < RANDOM_CMDS; i++) begin
      if (phase_left == 0) begin
        ph         = phase_t'($urandom_range(PH_MIXED, PH_FILL));
        phase_left = $urandom_range(40, 10);
        idle_odds  = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
      end
      phase_left--;
      if (i == RANDOM_CMDS - QUIET_CMDS) quiet = 1'b1;
      send_cmd(pick_func(ph), pick_value());
    end
    cmd_valid <= 1'b0;

    // let outstanding responses drain
    while (sb.pending_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending_rsps.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/deb_pkg.sv
hw/rtl/deb_ram.sv
hw/rtl/double_ended_buffer_with_reverse.sv
dv/double_ended_buffer_with_reverse_test.sv
